// ===== src/etcd_pkg.sv =====
// ----------------------------------------------------------------------------
// etcd_pkg
// Shared types, constants and tables for the epoch to calendar date pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package etcd_pkg;

    localparam logic [31:0] LIMIT_EPOCH = 32'd4102444800;

    // seconds / 86400 = (seconds >> 7) / 675
    localparam int unsigned DAY_LOW_BITS = 7;
    localparam int unsigned DAY_DIV      = 675;
    localparam int unsigned DAY_SHIFT    = 25;
    localparam int unsigned DAY_RECIP    = (2 ** DAY_SHIFT) / DAY_DIV;

    localparam int unsigned DAYS_BEFORE_EPOCH = 731;
    localparam int unsigned CYCLE_BASE_YEAR   = 1968;
    localparam int unsigned DAYS_PER_CYCLE    = 1461;
    localparam int unsigned CYCLE_SHIFT       = 16;
    localparam int unsigned CYCLE_RECIP       = (2 ** CYCLE_SHIFT) / DAYS_PER_CYCLE;

    localparam int unsigned EPOCH_WEEKDAY = 4;
    localparam int unsigned WEEK_DAYS     = 7;
    localparam int unsigned WEEK_SHIFT    = 16;
    localparam int unsigned WEEK_RECIP    = (2 ** WEEK_SHIFT) / WEEK_DAYS;

    localparam int unsigned SIXTY        = 60;
    localparam int unsigned MIN_SHIFT    = 17;
    localparam int unsigned MIN_RECIP    = (2 ** MIN_SHIFT) / SIXTY;
    localparam int unsigned HOUR_SHIFT   = 11;
    localparam int unsigned HOUR_RECIP   = (2 ** HOUR_SHIFT) / SIXTY;

    localparam int unsigned LEAP_YEAR_DAYS = 366;
    localparam int unsigned YEAR_DAYS      = 365;
    localparam int unsigned MONTHS         = 12;

    typedef struct packed {
        logic        oor;
        logic [15:0] days;
        logic [16:0] secs;
    } etcd_split_t;

    typedef struct packed {
        logic        oor;
        logic [5:0]  cycles;
        logic [10:0] cycle_day;
        logic [2:0]  weekday;
        logic [10:0] mins;
        logic [5:0]  second;
    } etcd_field_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic        out_of_range;
    } etcd_date_t;

    // First day of year of each month, counted from zero.
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        base = 9'd0;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (idx >= 4'd2))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// ===== src/etcd_epoch_if.sv =====
// ----------------------------------------------------------------------------
// etcd_epoch_if
// Channel carrying one epoch second count per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface etcd_epoch_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ===== src/etcd_date_if.sv =====
// ----------------------------------------------------------------------------
// etcd_date_if
// Channel carrying one calendar date and time of day per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface etcd_date_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        out_of_range;

    modport source (output valid, output year, output month, output day, output hour,
                    output minute, output second, output weekday, output out_of_range,
                    input ready);
    modport sink   (input valid, input year, input month, input day, input hour,
                    input minute, input second, input weekday, input out_of_range,
                    output ready);
endinterface

// ===== src/etcd_day_split.sv =====
// ----------------------------------------------------------------------------
// etcd_day_split
// Two stages: split the second count into whole days and seconds of day by
// reciprocal multiplication, then correct the quotient by one compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etcd_day_split (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 epoch_valid,
    output logic                 epoch_ready,
    input  logic [31:0]          epoch_seconds,
    output logic                 split_valid,
    input  logic                 split_ready,
    output etcd_pkg::etcd_split_t split
);

    localparam int unsigned XW = 32 - etcd_pkg::DAY_LOW_BITS;
    localparam int unsigned PW = XW + 16;

    logic                          a_valid_reg;
    logic                          b_valid_reg;
    logic                          a_adv;
    logic                          b_adv;

    logic                          a_oor_reg;
    logic [XW-1:0]                 a_x_reg;
    logic [etcd_pkg::DAY_LOW_BITS-1:0] a_low_reg;
    logic [15:0]                   a_q_reg;
    logic [PW-1:0]                 day_prod;

    logic [XW-1:0]                 day_back;
    logic [10:0]                   day_rem_raw;
    logic                          day_fix;
    logic [9:0]                    day_rem;
    etcd_pkg::etcd_split_t         split_next;
    etcd_pkg::etcd_split_t         split_reg;

    assign b_adv       = !b_valid_reg || split_ready;
    assign a_adv       = !a_valid_reg || b_adv;
    assign epoch_ready = a_adv;

    assign day_prod = PW'(epoch_seconds[31:etcd_pkg::DAY_LOW_BITS])
                    * PW'(etcd_pkg::DAY_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= epoch_valid;
            end
            if (b_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            a_oor_reg <= (epoch_seconds >= etcd_pkg::LIMIT_EPOCH);
            a_x_reg   <= epoch_seconds[31:etcd_pkg::DAY_LOW_BITS];
            a_low_reg <= epoch_seconds[etcd_pkg::DAY_LOW_BITS-1:0];
            a_q_reg   <= day_prod[etcd_pkg::DAY_SHIFT +: 16];
        end
    end

    assign day_back    = XW'(a_q_reg) * XW'(etcd_pkg::DAY_DIV);
    assign day_rem_raw = 11'(a_x_reg - day_back);
    assign day_fix     = (day_rem_raw >= 11'(etcd_pkg::DAY_DIV));
    assign day_rem     = day_fix ? 10'(day_rem_raw - 11'(etcd_pkg::DAY_DIV))
                                 : day_rem_raw[9:0];

    always_comb
    begin
        split_next.oor  = a_oor_reg;
        split_next.days = a_q_reg + 16'(day_fix);
        split_next.secs = {day_rem, a_low_reg};
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            split_reg <= split_next;
        end
    end

    assign split_valid = b_valid_reg;
    assign split       = split_reg;

endmodule

// ===== src/etcd_field_div.sv =====
// ----------------------------------------------------------------------------
// etcd_field_div
// Two stages: divide the day count by the four-year cycle and by the week,
// and the seconds of day by sixty, each by reciprocal multiply and correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etcd_field_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  split_valid,
    output logic                  split_ready,
    input  etcd_pkg::etcd_split_t split,
    output logic                  field_valid,
    input  logic                  field_ready,
    output etcd_pkg::etcd_field_t field
);

    logic        a_valid_reg;
    logic        b_valid_reg;
    logic        a_adv;
    logic        b_adv;

    logic [15:0] cyc_day;
    logic [15:0] week_day;
    logic [21:0] cyc_prod;
    logic [29:0] week_prod;
    logic [28:0] min_prod;

    logic        a_oor_reg;
    logic [15:0] a_cyc_day_reg;
    logic [5:0]  a_cyc_q_reg;
    logic [15:0] a_week_day_reg;
    logic [13:0] a_week_q_reg;
    logic [16:0] a_secs_reg;
    logic [10:0] a_min_q_reg;

    logic [11:0] cyc_rem_raw;
    logic        cyc_fix;
    logic [3:0]  week_rem_raw;
    logic        week_fix;
    logic [6:0]  sec_rem_raw;
    logic        sec_fix;

    etcd_pkg::etcd_field_t field_next;
    etcd_pkg::etcd_field_t field_reg;

    assign b_adv       = !b_valid_reg || field_ready;
    assign a_adv       = !a_valid_reg || b_adv;
    assign split_ready = a_adv;

    assign cyc_day   = split.days + 16'(etcd_pkg::DAYS_BEFORE_EPOCH);
    assign week_day  = split.days + 16'(etcd_pkg::EPOCH_WEEKDAY);
    assign cyc_prod  = 22'(cyc_day) * 22'(etcd_pkg::CYCLE_RECIP);
    assign week_prod = 30'(week_day) * 30'(etcd_pkg::WEEK_RECIP);
    assign min_prod  = 29'(split.secs) * 29'(etcd_pkg::MIN_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= split_valid;
            end
            if (b_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            a_oor_reg      <= split.oor;
            a_cyc_day_reg  <= cyc_day;
            a_cyc_q_reg    <= cyc_prod[etcd_pkg::CYCLE_SHIFT +: 6];
            a_week_day_reg <= week_day;
            a_week_q_reg   <= week_prod[etcd_pkg::WEEK_SHIFT +: 14];
            a_secs_reg     <= split.secs;
            a_min_q_reg    <= min_prod[etcd_pkg::MIN_SHIFT +: 11];
        end
    end

    assign cyc_rem_raw  = 12'(a_cyc_day_reg
                        - 16'(a_cyc_q_reg) * 16'(etcd_pkg::DAYS_PER_CYCLE));
    assign cyc_fix      = (cyc_rem_raw >= 12'(etcd_pkg::DAYS_PER_CYCLE));
    assign week_rem_raw = 4'(a_week_day_reg
                        - 16'(a_week_q_reg) * 16'(etcd_pkg::WEEK_DAYS));
    assign week_fix     = (week_rem_raw >= 4'(etcd_pkg::WEEK_DAYS));
    assign sec_rem_raw  = 7'(a_secs_reg - 17'(a_min_q_reg) * 17'(etcd_pkg::SIXTY));
    assign sec_fix      = (sec_rem_raw >= 7'(etcd_pkg::SIXTY));

    always_comb
    begin
        field_next.oor       = a_oor_reg;
        field_next.cycles    = a_cyc_q_reg + 6'(cyc_fix);
        field_next.cycle_day = cyc_fix
                             ? 11'(cyc_rem_raw - 12'(etcd_pkg::DAYS_PER_CYCLE))
                             : cyc_rem_raw[10:0];
        field_next.weekday   = week_fix
                             ? 3'(week_rem_raw - 4'(etcd_pkg::WEEK_DAYS))
                             : week_rem_raw[2:0];
        field_next.mins      = a_min_q_reg + 11'(sec_fix);
        field_next.second    = sec_fix
                             ? 6'(sec_rem_raw - 7'(etcd_pkg::SIXTY))
                             : sec_rem_raw[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            field_reg <= field_next;
        end
    end

    assign field_valid = b_valid_reg;
    assign field       = field_reg;

endmodule

// ===== src/etcd_calendar.sv =====
// ----------------------------------------------------------------------------
// etcd_calendar
// Two stages: place the day within its four-year cycle and split minutes into
// hours, then find the month by parallel compares and hold the final result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etcd_calendar (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  field_valid,
    output logic                  field_ready,
    input  etcd_pkg::etcd_field_t field,
    output logic                  date_valid,
    input  logic                  date_ready,
    output etcd_pkg::etcd_date_t  date
);

    localparam int unsigned Y1 = etcd_pkg::LEAP_YEAR_DAYS;
    localparam int unsigned Y2 = Y1 + etcd_pkg::YEAR_DAYS;
    localparam int unsigned Y3 = Y2 + etcd_pkg::YEAR_DAYS;

    logic        a_valid_reg;
    logic        b_valid_reg;
    logic        a_adv;
    logic        b_adv;

    logic [1:0]  year_off;
    logic [8:0]  doy_next;
    logic [16:0] hour_prod;

    logic        a_oor_reg;
    logic [11:0] a_year_reg;
    logic [8:0]  a_doy_reg;
    logic        a_leap_reg;
    logic [10:0] a_mins_reg;
    logic [5:0]  a_hour_q_reg;
    logic [5:0]  a_second_reg;
    logic [2:0]  a_weekday_reg;

    logic [3:0]  month_idx;
    logic [8:0]  month_base;
    logic [6:0]  min_rem_raw;
    logic        min_fix;

    etcd_pkg::etcd_date_t date_next;
    etcd_pkg::etcd_date_t date_reg;

    assign b_adv       = !b_valid_reg || date_ready;
    assign a_adv       = !a_valid_reg || b_adv;
    assign field_ready = a_adv;

    always_comb
    begin
        if (field.cycle_day < 11'(Y1))
        begin
            year_off = 2'd0;
            doy_next = field.cycle_day[8:0];
        end
        else if (field.cycle_day < 11'(Y2))
        begin
            year_off = 2'd1;
            doy_next = 9'(field.cycle_day - 11'(Y1));
        end
        else if (field.cycle_day < 11'(Y3))
        begin
            year_off = 2'd2;
            doy_next = 9'(field.cycle_day - 11'(Y2));
        end
        else
        begin
            year_off = 2'd3;
            doy_next = 9'(field.cycle_day - 11'(Y3));
        end
    end

    assign hour_prod = 17'(field.mins) * 17'(etcd_pkg::HOUR_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= field_valid;
            end
            if (b_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            a_oor_reg     <= field.oor;
            a_year_reg    <= 12'(etcd_pkg::CYCLE_BASE_YEAR) + 12'({field.cycles, year_off});
            a_doy_reg     <= doy_next;
            a_leap_reg    <= (year_off == 2'd0);
            a_mins_reg    <= field.mins;
            a_hour_q_reg  <= hour_prod[etcd_pkg::HOUR_SHIFT +: 6];
            a_second_reg  <= field.second;
            a_weekday_reg <= field.weekday;
        end
    end

    // Month starts rise, so the count of starts passed is the month index.
    always_comb
    begin
        month_idx = 4'd0;
        for (int i = 1; i < etcd_pkg::MONTHS; i++)
        begin
            month_idx = month_idx
                      + 4'(a_doy_reg >= etcd_pkg::month_start(4'(i), a_leap_reg));
        end
    end

    assign month_base  = etcd_pkg::month_start(month_idx, a_leap_reg);
    assign min_rem_raw = 7'(a_mins_reg - 11'(a_hour_q_reg) * 11'(etcd_pkg::SIXTY));
    assign min_fix     = (min_rem_raw >= 7'(etcd_pkg::SIXTY));

    always_comb
    begin
        date_next = '0;
        date_next.out_of_range = a_oor_reg;
        if (!a_oor_reg)
        begin
            date_next.year    = a_year_reg;
            date_next.month   = month_idx + 4'd1;
            date_next.day     = 5'(a_doy_reg - month_base + 9'd1);
            date_next.hour    = 5'(a_hour_q_reg + 6'(min_fix));
            date_next.minute  = min_fix ? 6'(min_rem_raw - 7'(etcd_pkg::SIXTY))
                                        : min_rem_raw[5:0];
            date_next.second  = a_second_reg;
            date_next.weekday = a_weekday_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            date_reg <= date_next;
        end
    end

    assign date_valid = b_valid_reg;
    assign date       = date_reg;

endmodule

// ===== src/epoch_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// epoch_to_calendar_date
// Converts a 32-bit Unix second count into year, month, day, hour, minute,
// second and weekday (Sunday = 0), treating every fourth year as a leap year.
// Counts at or beyond 2100-01-01 00:00:00 set out_of_range with all other
// fields zero. The block accepts one transaction every clock while the output
// is not stalled, and passes each through three divide steps (days, four-year
// cycles, minutes/hours), each a reciprocal multiply stage followed by a
// correction stage. A stall on the output backs up through the stages without
// losing or repeating a transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_to_calendar_date (
    input logic               clk,
    input logic               rst_n,
    etcd_epoch_if.sink        epoch,
    etcd_date_if.source       date
);

    logic                  split_valid;
    logic                  split_ready;
    etcd_pkg::etcd_split_t split;
    logic                  field_valid;
    logic                  field_ready;
    etcd_pkg::etcd_field_t field;
    etcd_pkg::etcd_date_t  result;

    etcd_day_split u_day_split (
        .clk           (clk),
        .rst_n         (rst_n),
        .epoch_valid   (epoch.valid),
        .epoch_ready   (epoch.ready),
        .epoch_seconds (epoch.epoch_seconds),
        .split_valid   (split_valid),
        .split_ready   (split_ready),
        .split         (split)
    );

    etcd_field_div u_field_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .split_valid (split_valid),
        .split_ready (split_ready),
        .split       (split),
        .field_valid (field_valid),
        .field_ready (field_ready),
        .field       (field)
    );

    etcd_calendar u_calendar (
        .clk         (clk),
        .rst_n       (rst_n),
        .field_valid (field_valid),
        .field_ready (field_ready),
        .field       (field),
        .date_valid  (date.valid),
        .date_ready  (date.ready),
        .date        (result)
    );

    assign date.year         = result.year;
    assign date.month        = result.month;
    assign date.day          = result.day;
    assign date.hour         = result.hour;
    assign date.minute       = result.minute;
    assign date.second       = result.second;
    assign date.weekday      = result.weekday;
    assign date.out_of_range = result.out_of_range;

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        date.valid && date.out_of_range |->
            date.year == 12'd0 && date.month == 4'd0 && date.day == 5'd0 &&
            date.hour == 5'd0 && date.minute == 6'd0 && date.second == 6'd0 &&
            date.weekday == 3'd0)
        else $error("out of range result carries nonzero fields");

    a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
        date.valid && !date.out_of_range |->
            date.year >= 12'd1970 && date.year <= 12'd2099 &&
            date.month >= 4'd1 && date.month <= 4'd12 &&
            date.day >= 5'd1 && date.hour <= 5'd23 &&
            date.minute <= 6'd59 && date.second <= 6'd59 && date.weekday <= 3'd6)
        else $error("date field outside its range");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !epoch.ready |-> date.valid && !date.ready)
        else $error("input stalled while the output drains");

endmodule

// ===== tb/epoch_to_calendar_date_checker.sv =====
// ----------------------------------------------------------------------------
// epoch_to_calendar_date_checker
// Watches the epoch and date channels of the converter. Every accepted epoch
// count is turned into the expected calendar date and queued. Every accepted
// date is compared, field by field, with the oldest queued date.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_to_calendar_date_checker (
    input  logic        clk,
    input  logic        rst_n,
    etcd_epoch_if       epoch_mon,
    etcd_date_if        date_mon,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned checked,
    output int unsigned beyond
);

    localparam int unsigned DAY_SECONDS = 86400;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    etcd_pkg::etcd_date_t dates_due [$];
    int unsigned          mismatches;
    int unsigned          strays;

    function automatic etcd_pkg::etcd_date_t calendar_of(input logic [31:0] t);
        etcd_pkg::etcd_date_t r;
        int unsigned days;
        int unsigned secs;
        int unsigned d;
        int unsigned yr;
        int unsigned rem;
        int unsigned yrs;
        int unsigned mon;
        int unsigned mlen;
        logic        leap;
        r = '0;
        if (t >= etcd_pkg::LIMIT_EPOCH)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        days = t / DAY_SECONDS;
        secs = t % DAY_SECONDS;
        d    = days + etcd_pkg::DAYS_BEFORE_EPOCH;
        yr   = etcd_pkg::CYCLE_BASE_YEAR + 4 * (d / etcd_pkg::DAYS_PER_CYCLE);
        rem  = d % etcd_pkg::DAYS_PER_CYCLE;
        if (rem >= etcd_pkg::LEAP_YEAR_DAYS)
        begin
            rem = rem - etcd_pkg::LEAP_YEAR_DAYS;
            yrs = rem / etcd_pkg::YEAR_DAYS;
            yr  = yr + 1 + yrs;
            rem = rem - etcd_pkg::YEAR_DAYS * yrs;
        end
        leap = (yr % 4) == 0;
        for (mon = 0; mon < etcd_pkg::MONTHS - 1; mon++)
        begin
            mlen = MONTH_DAYS[mon] + ((mon == 1 && leap) ? 1 : 0);
            if (rem < mlen)
                break;
            rem = rem - mlen;
        end
        r.year    = 12'(yr);
        r.month   = 4'(mon + 1);
        r.day     = 5'(rem + 1);
        r.hour    = 5'(secs / 3600);
        r.minute  = 6'((secs / etcd_pkg::SIXTY) % etcd_pkg::SIXTY);
        r.second  = 6'(secs % etcd_pkg::SIXTY);
        r.weekday = 3'((days + etcd_pkg::EPOCH_WEEKDAY) % etcd_pkg::WEEK_DAYS);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        etcd_pkg::etcd_date_t got;
        etcd_pkg::etcd_date_t want;
        if (!rst_n)
        begin
            dates_due.delete();
            mismatches = 0;
            strays     = 0;
            checked    = 0;
            beyond     = 0;
        end
        else
        begin
            if (epoch_mon.valid && epoch_mon.ready)
                dates_due.push_back(calendar_of(epoch_mon.epoch_seconds));
            if (date_mon.valid && date_mon.ready)
            begin
                got.year         = date_mon.year;
                got.month        = date_mon.month;
                got.day          = date_mon.day;
                got.hour         = date_mon.hour;
                got.minute       = date_mon.minute;
                got.second       = date_mon.second;
                got.weekday      = date_mon.weekday;
                got.out_of_range = date_mon.out_of_range;
                if (dates_due.size() == 0)
                begin
                    strays++;
                    if (mismatches + strays <= MAX_REPORTS)
                        $display("%0t: date transaction with none outstanding: %p", $time, got);
                end
                else
                begin
                    want = dates_due.pop_front();
                    checked++;
                    if (want.out_of_range)
                        beyond++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches + strays <= MAX_REPORTS)
                            $display("%0t: date mismatch\n  expected %p\n  actual   %p",
                                     $time, want, got);
                    end
                end
            end
        end
        fail_count = mismatches + strays;
        pending    = dates_due.size();
    end

endmodule

// ===== tb/epoch_to_calendar_date_tb.sv =====
// ----------------------------------------------------------------------------
// epoch_to_calendar_date_tb
// Drives epoch counts into the converter: a directed set of day, year, leap
// day and end of range boundaries, then random counts weighted toward valid
// dates and boundaries. Both channels idle at random, the date side holds off
// long enough to back up the pipeline, and a checker scores every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_to_calendar_date_tb;

    localparam int unsigned RANDOM_COUNT = 1700;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned LAST_DAY     = 47481;
    localparam int unsigned DAY_SECONDS  = 86400;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned beyond;
    int unsigned cycle_count;

    etcd_epoch_if epoch_ch ();
    etcd_date_if  date_ch ();

    epoch_to_calendar_date u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .epoch (epoch_ch),
        .date  (date_ch)
    );

    epoch_to_calendar_date_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .epoch_mon  (epoch_ch),
        .date_mon   (date_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .beyond     (beyond)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] random_epoch();
        int unsigned y;
        int unsigned days;
        int unsigned off;
        logic [31:0] t;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: t = $urandom_range(0, etcd_pkg::LIMIT_EPOCH - 1);
            5:             t = $urandom;
            6:
            begin
                t = $urandom_range(0, LAST_DAY) * DAY_SECONDS;
                if ($urandom_range(0, 1))
                    t = t + DAY_SECONDS - 1;
            end
            7:
            begin
                y = $urandom_range(1970, 2099);
                days = (y - 1970) * etcd_pkg::YEAR_DAYS + (y - 1969) / 4;
                case ($urandom_range(0, 5))
                    0:       off = 0;
                    1:       off = 58;
                    2:       off = 59;
                    3:       off = 60;
                    4:       off = 364;
                    default: off = 365;
                endcase
                t = (days + off) * DAY_SECONDS;
                t = t + $urandom_range(0, 2) - 1;
            end
            8:       t = etcd_pkg::LIMIT_EPOCH + $urandom_range(0, 200000) - 100000;
            default: t = $urandom_range(etcd_pkg::LIMIT_EPOCH, 32'hFFFF_FFFF);
        endcase
        return t;
    endfunction

    task automatic offer_epoch(input logic [31:0] t);
        epoch_ch.valid         <= 1'b1;
        epoch_ch.epoch_seconds <= t;
        do
            @(posedge clk);
        while (!epoch_ch.ready);
        @(negedge clk);
    endtask

    task automatic idle_epoch();
        epoch_ch.valid         <= 1'b0;
        epoch_ch.epoch_seconds <= $urandom;
        @(negedge clk);
    endtask

    // date side: random hold-offs, one long hold, one calm window
    initial
    begin
        int unsigned cyc;
        int unsigned hold;
        date_ch.ready = 1'b0;
        cyc  = 0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc == 800)
                hold = 300;
            if (hold > 0)
            begin
                date_ch.ready <= 1'b0;
                hold--;
            end
            else if (cyc >= 1400 && cyc < 1900)
                date_ch.ready <= 1'b1;
            else
                date_ch.ready <= ($urandom_range(0, 99) >= 20);
        end
    end

    initial
    begin
        logic [31:0] directed [$];
        int unsigned i;
        directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                     32'd86400, 32'd31535999, 32'd31536000, 32'd63071999, 32'd63072000,
                     32'd68169599, 32'd68169600, 32'd68255999, 32'd68256000,
                     32'd951782400, 32'd2147483647, 32'd2147483648,
                     32'd4102444799, 32'd4102444800, 32'd4294967295,
                     32'hAAAA_AAAA, 32'h5555_5555};
        rst_n                  = 1'b0;
        epoch_ch.valid         = 1'b0;
        epoch_ch.epoch_seconds = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[k])
        begin
            if ($urandom_range(0, 99) < 20)
                idle_epoch();
            offer_epoch(directed[k]);
        end

        // pause until the pipeline is empty
        epoch_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);

        for (i = 0; i < RANDOM_COUNT; i++)
        begin
            if ((i < 900 || i >= 1200) && $urandom_range(0, 99) < 20)
                idle_epoch();
            offer_epoch(random_epoch());
        end

        epoch_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d dates from directed boundaries and random epoch counts,",
                 checked);
        $display("%0d of them beyond 2099, in %0d cycles with stalls on both sides.",
                 beyond, cycle_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
